>>> sv/ral_pkg.sv
// Shared types and constants for the ranked array list core.
`timescale 1ns / 1ps
`default_nettype none

package ral_pkg;

    localparam int DATA_W          = 32;
    localparam int KIND_W          = 4;
    localparam int RANK_W          = 5;
    localparam int OTHER_W         = 4;
    localparam int CNT_FW          = 5;
    localparam int CAP_W           = 5;
    localparam int STAT_W          = 2;
    localparam int MAX_ENTRIES_DEF = 16;
    localparam logic [CAP_W-1:0] CAP_RESET = 5'd10;

    // stream word layouts, first field in the lowest bits
    localparam int S_TDATA_W = 48;  // rank, other_rank, value
    localparam int M_TDATA_W = 40;  // result_value, entry_count

    typedef enum logic [KIND_W-1:0] {
        KIND_INS_FRONT = 4'd0,
        KIND_INS_END   = 4'd1,
        KIND_INS_RANK  = 4'd2,
        KIND_REPLACE   = 4'd3,
        KIND_DEL_FRONT = 4'd4,
        KIND_DEL_END   = 4'd5,
        KIND_DEL_RANK  = 4'd6,
        KIND_READ      = 4'd7,
        KIND_SWAP      = 4'd8,
        KIND_SUM       = 4'd9,
        KIND_MAX       = 4'd10,
        KIND_MIN       = 4'd11,
        KIND_REVERSE   = 4'd12
    } kind_t;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK    = 2'd0,
        STAT_FULL  = 2'd1,
        STAT_EMPTY = 2'd2,
        STAT_RANGE = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SWEEP,
        S_COMMIT,
        S_REVERSE,
        S_FINISH
    } state_t;

    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_SHR,    // insert: cells above pos take left, cell at pos takes val_a
        CELL_SHL,    // delete / rotate: cells at or above pos take right
        CELL_WRITE,  // cell pos_a takes val_a, cell pos_b takes val_b
        CELL_XCHG    // one odd-even exchange round below count
    } cell_op_t;

    typedef struct packed {
        cell_op_t          op;
        logic              parity;
        logic [DATA_W-1:0] val_a;
        logic [DATA_W-1:0] val_b;
    } ral_ctrl_t;

endpackage

`default_nettype wire

>>> sv/ral_cell.sv
// One list entry of the cell row, exchanging data with its two neighbors.
`timescale 1ns / 1ps
`default_nettype none

module ral_cell
    import ral_pkg::*;
#(
    parameter int CW  = 5,
    parameter int IDX = 0
)
(
    input  wire logic              clk,
    input  wire ral_ctrl_t         ctrl,
    input  wire logic [CW-1:0]     pos_a,
    input  wire logic [CW-1:0]     pos_b,
    input  wire logic [CW-1:0]     count,
    input  wire logic [DATA_W-1:0] left_data,
    input  wire logic [DATA_W-1:0] right_data,
    output logic      [DATA_W-1:0] data
);

    localparam logic [CW-1:0] IDX_C  = CW'(IDX);
    localparam logic [CW-1:0] NEXT_C = CW'(IDX + 1);
    localparam bit ODD      = (IDX % 2) == 1;
    localparam bit HAS_LEFT = (IDX != 0);

    logic [DATA_W-1:0] data_reg;
    logic [DATA_W-1:0] data_next;

    always_comb
    begin
        data_next = data_reg;
        case (ctrl.op)
            CELL_SHR:
            begin
                if (IDX_C > pos_a)
                    data_next = left_data;
                else if (IDX_C == pos_a)
                    data_next = ctrl.val_a;
            end
            CELL_SHL:
            begin
                if (IDX_C >= pos_a)
                    data_next = right_data;
            end
            CELL_WRITE:
            begin
                if (IDX_C == pos_a)
                    data_next = ctrl.val_a;
                else if (IDX_C == pos_b)
                    data_next = ctrl.val_b;
            end
            CELL_XCHG:
            begin
                // pair (j, j+1) exchanges when j has the round's parity
                if ((ODD == ctrl.parity) && (NEXT_C < count))
                    data_next = right_data;
                else if ((ODD != ctrl.parity) && HAS_LEFT && (IDX_C < count))
                    data_next = left_data;
            end
            default:
            begin
                data_next = data_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

`default_nettype wire

>>> sv/ranked_array_list_core.sv
// Top level of the ranked array list: control sequencer over a row of entry cells.
`timescale 1ns / 1ps
`default_nettype none

// Keeps an ordered list of up to MAX_ENTRIES signed 32-bit words in a row of
// cells, bounded by the capacity register. One input word runs one operation
// and gives one result word. Inserts, replace and undefined kinds go from
// accept straight to the commit state; read, delete, swap, sum, max and min
// first sweep, since the row rotates once past the tap at cell 0; reverse
// runs one odd-even exchange round per entry; a failed check goes straight to
// the finish state. The result sits in an output register, and the next word
// is taken while it waits. No pass is needed after reset: entries at or above
// the count are never read.
module ranked_array_list_core
    import ral_pkg::*;
#(
    parameter int MAX_ENTRIES = MAX_ENTRIES_DEF
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_wr_en,
    input  wire logic [CAP_W-1:0]     cfg_wr_data,   // capacity_limit
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [S_TDATA_W-1:0] s_tdata,       // rank[4:0], other_rank[8:5], value[40:9]
    input  wire logic [KIND_W-1:0]    s_tuser,       // kind[3:0]
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [M_TDATA_W-1:0]      m_tdata,       // result_value[31:0], entry_count[36:32]
    output logic [STAT_W-1:0]         m_tuser        // status[1:0]
);

    localparam int CW   = $clog2(MAX_ENTRIES + 1);
    localparam int IW   = $clog2(MAX_ENTRIES);
    localparam int CMPW = (CW > RANK_W) ? CW : RANK_W;
    localparam logic [IW-1:0]   STEP_LAST = IW'(MAX_ENTRIES - 1);
    localparam logic [CMPW-1:0] N_X       = CMPW'(MAX_ENTRIES);

    // input unpacking
    logic [RANK_W-1:0]  in_rank;
    logic [OTHER_W-1:0] in_other;
    logic [DATA_W-1:0]  in_value;
    logic               in_accept;

    assign in_rank   = s_tdata[RANK_W-1:0];
    assign in_other  = s_tdata[RANK_W+OTHER_W-1:RANK_W];
    assign in_value  = s_tdata[RANK_W+OTHER_W+DATA_W-1:RANK_W+OTHER_W];
    assign in_accept = s_tvalid && s_tready;

    // registers
    state_t             state_reg,    state_next;
    logic [CW-1:0]      count_reg,    count_next;
    logic [CAP_W-1:0]   cap_reg,      cap_next;
    logic               m_tvalid_reg, m_tvalid_next;
    kind_t              kind_reg,     kind_next;
    status_t            st_reg,       st_next;
    logic [CW-1:0]      pos_a_reg,    pos_a_next;
    logic [CW-1:0]      pos_b_reg,    pos_b_next;
    logic [DATA_W-1:0]  val_reg,      val_next;
    logic [IW-1:0]      step_reg,     step_next;
    logic [CW-1:0]      rnd_reg,      rnd_next;
    logic [DATA_W-1:0]  acc_reg,      acc_next;
    logic [DATA_W-1:0]  cap_a_reg,    cap_a_next;
    logic [DATA_W-1:0]  cap_b_reg,    cap_b_next;
    logic [DATA_W-1:0]  m_value_reg,  m_value_next;
    status_t            m_status_reg, m_status_next;
    logic [CNT_FW-1:0]  m_count_reg,  m_count_next;

    // cell row
    ral_ctrl_t          cell_ctrl;
    logic [CW-1:0]      cell_pos_a;
    logic [CW-1:0]      cell_pos_b;
    logic [DATA_W-1:0]  cell_data [MAX_ENTRIES];
    logic [DATA_W-1:0]  tap;

    assign tap = cell_data[0];

    for (genvar gi = 0; gi < MAX_ENTRIES; gi++)
    begin : g_cell
        logic [DATA_W-1:0] left_w;
        logic [DATA_W-1:0] right_w;

        if (gi == 0)
        begin : g_first
            assign left_w = '0;
        end
        else
        begin : g_mid
            assign left_w = cell_data[gi-1];
        end

        // the last cell closes the ring so a full rotation restores the row
        if (gi == MAX_ENTRIES - 1)
        begin : g_last
            assign right_w = cell_data[0];
        end
        else
        begin : g_inner
            assign right_w = cell_data[gi+1];
        end

        ral_cell #(
            .CW  (CW),
            .IDX (gi)
        ) u_cell (
            .clk        (clk),
            .ctrl       (cell_ctrl),
            .pos_a      (cell_pos_a),
            .pos_b      (cell_pos_b),
            .count      (count_reg),
            .left_data  (left_w),
            .right_data (right_w),
            .data       (cell_data[gi])
        );
    end

    // checks on the current list
    logic [CMPW-1:0] cnt_x;
    logic [CMPW-1:0] rank_x;
    logic [CMPW-1:0] other_x;
    logic [CMPW-1:0] cap_x;
    logic            full;
    logic            empty;
    logic [CW-1:0]   step_x;
    logic            step_in;

    assign cnt_x   = CMPW'(count_reg);
    assign rank_x  = CMPW'(in_rank);
    assign other_x = CMPW'(in_other);
    assign cap_x   = CMPW'(cap_reg);
    assign full    = (cap_reg == '0) ? (count_reg != '0)
                                     : ((cnt_x >= cap_x) || (cnt_x >= N_X));
    assign empty   = (count_reg == '0);
    assign step_x  = CW'(step_reg);
    assign step_in = (step_x < count_reg);

    assign s_tready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next    = state_reg;
        count_next    = count_reg;
        cap_next      = cfg_wr_en ? cfg_wr_data : cap_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        kind_next     = kind_reg;
        st_next       = st_reg;
        pos_a_next    = pos_a_reg;
        pos_b_next    = pos_b_reg;
        val_next      = val_reg;
        step_next     = step_reg;
        rnd_next      = rnd_reg;
        acc_next      = acc_reg;
        cap_a_next    = cap_a_reg;
        cap_b_next    = cap_b_reg;
        m_value_next  = m_value_reg;
        m_status_next = m_status_reg;
        m_count_next  = m_count_reg;

        cell_ctrl.op     = CELL_HOLD;
        cell_ctrl.parity = rnd_reg[0];
        cell_ctrl.val_a  = val_reg;
        cell_ctrl.val_b  = val_reg;
        cell_pos_a       = pos_a_reg;
        cell_pos_b       = pos_b_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    kind_next  = kind_t'(s_tuser);
                    val_next   = in_value;
                    pos_a_next = CW'(rank_x);
                    pos_b_next = CW'(other_x);
                    step_next  = '0;
                    rnd_next   = '0;
                    acc_next   = '0;
                    st_next    = STAT_OK;
                    state_next = S_COMMIT;
                    case (kind_t'(s_tuser))
                        KIND_INS_FRONT, KIND_INS_END, KIND_INS_RANK:
                        begin
                            if (full)
                                st_next = STAT_FULL;
                            else if ((kind_t'(s_tuser) == KIND_INS_RANK) && (rank_x > cnt_x))
                                st_next = STAT_RANGE;
                            if (kind_t'(s_tuser) == KIND_INS_FRONT)
                                pos_a_next = '0;
                            else if (kind_t'(s_tuser) == KIND_INS_END)
                                pos_a_next = count_reg;
                        end
                        KIND_REPLACE, KIND_DEL_RANK, KIND_READ:
                        begin
                            if (empty)
                                st_next = STAT_EMPTY;
                            else if (rank_x >= cnt_x)
                                st_next = STAT_RANGE;
                            if (kind_t'(s_tuser) != KIND_REPLACE)
                                state_next = S_SWEEP;
                        end
                        KIND_DEL_FRONT, KIND_DEL_END:
                        begin
                            if (empty)
                                st_next = STAT_EMPTY;
                            pos_a_next = (kind_t'(s_tuser) == KIND_DEL_FRONT)
                                       ? '0 : (count_reg - 1'b1);
                            state_next = S_SWEEP;
                        end
                        KIND_SWAP:
                        begin
                            if ((rank_x >= cnt_x) || (other_x >= cnt_x))
                                st_next = STAT_RANGE;
                            state_next = S_SWEEP;
                        end
                        KIND_SUM, KIND_MAX, KIND_MIN:
                        begin
                            if (empty)
                                st_next = STAT_EMPTY;
                            state_next = S_SWEEP;
                        end
                        KIND_REVERSE:
                        begin
                            if (empty)
                                st_next = STAT_EMPTY;
                            state_next = S_REVERSE;
                        end
                        default:
                        begin
                            state_next = S_COMMIT;
                        end
                    endcase
                    // a failed check leaves the list alone
                    if (st_next != STAT_OK)
                        state_next = S_FINISH;
                end
            end

            S_SWEEP:
            begin
                // rotate the whole row; the tap holds entry step
                cell_ctrl.op = CELL_SHL;
                cell_pos_a   = '0;
                if (step_x == pos_a_reg)
                    cap_a_next = tap;
                if (step_x == pos_b_reg)
                    cap_b_next = tap;
                case (kind_reg)
                    KIND_SUM:
                    begin
                        if (step_in)
                            acc_next = acc_reg + tap;
                    end
                    KIND_MAX:
                    begin
                        if (step_reg == '0)
                            acc_next = tap;
                        else if (step_in && ($signed(tap) > $signed(acc_reg)))
                            acc_next = tap;
                    end
                    KIND_MIN:
                    begin
                        if (step_reg == '0)
                            acc_next = tap;
                        else if (step_in && ($signed(tap) < $signed(acc_reg)))
                            acc_next = tap;
                    end
                    default:
                    begin
                        acc_next = acc_reg;
                    end
                endcase
                step_next = step_reg + 1'b1;
                if (step_reg == STEP_LAST)
                    state_next = S_COMMIT;
            end

            S_COMMIT:
            begin
                case (kind_reg)
                    KIND_INS_FRONT, KIND_INS_END, KIND_INS_RANK:
                    begin
                        cell_ctrl.op = CELL_SHR;
                        count_next   = count_reg + 1'b1;
                    end
                    KIND_REPLACE:
                    begin
                        cell_ctrl.op = CELL_WRITE;
                        cell_pos_b   = pos_a_reg;
                    end
                    KIND_DEL_FRONT, KIND_DEL_END, KIND_DEL_RANK:
                    begin
                        cell_ctrl.op = CELL_SHL;
                        count_next   = count_reg - 1'b1;
                    end
                    KIND_SWAP:
                    begin
                        cell_ctrl.op    = CELL_WRITE;
                        cell_ctrl.val_a = cap_b_reg;
                        cell_ctrl.val_b = cap_a_reg;
                    end
                    default:
                    begin
                        cell_ctrl.op = CELL_HOLD;
                    end
                endcase
                state_next = S_FINISH;
            end

            S_REVERSE:
            begin
                cell_ctrl.op = CELL_XCHG;
                rnd_next     = rnd_reg + 1'b1;
                if (rnd_reg == (count_reg - 1'b1))
                    state_next = S_FINISH;
            end

            S_FINISH:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    m_tvalid_next = 1'b1;
                    m_status_next = st_reg;
                    m_count_next  = CNT_FW'(count_reg);
                    if (st_reg != STAT_OK)
                        m_value_next = '1;
                    else
                    begin
                        case (kind_reg)
                            KIND_DEL_FRONT, KIND_DEL_END, KIND_DEL_RANK, KIND_READ:
                                m_value_next = cap_a_reg;
                            KIND_SUM, KIND_MAX, KIND_MIN:
                                m_value_next = acc_reg;
                            default:
                                m_value_next = '0;
                        endcase
                    end
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            count_reg    <= '0;
            cap_reg      <= CAP_RESET;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            cap_reg      <= cap_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg     <= kind_next;
        st_reg       <= st_next;
        pos_a_reg    <= pos_a_next;
        pos_b_reg    <= pos_b_next;
        val_reg      <= val_next;
        step_reg     <= step_next;
        rnd_reg      <= rnd_next;
        acc_reg      <= acc_next;
        cap_a_reg    <= cap_a_next;
        cap_b_reg    <= cap_b_next;
        m_value_reg  <= m_value_next;
        m_status_reg <= m_status_next;
        m_count_reg  <= m_count_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(M_TDATA_W - DATA_W - CNT_FW){1'b0}}, m_count_reg, m_value_reg};
    assign m_tuser  = m_status_reg;

endmodule

`default_nettype wire

>>> bench/ranked_array_list_core_tb.sv
// Self-checking testbench for the ranked array list core: directed table, then random phases.
`timescale 1ns / 1ps

module ranked_array_list_core_tb;
    import ral_pkg::*;

    localparam int ENTRY_DEPTH   = MAX_ENTRIES_DEF;
    localparam int RESET_CYCLES  = 6;
    localparam int IDLE_LIMIT    = 4000;   // well above the long receiver hold-off
    localparam int HOLD_CYCLES   = 300;
    localparam int SETTLE_CYCLES = MAX_ENTRIES_DEF + 4;
    localparam int DIRECTED_ROWS = 25;
    localparam int PHASES        = 6;
    localparam int PAD_W         = S_TDATA_W - RANK_W - OTHER_W - DATA_W;

    localparam logic [KIND_W-1:0] KIND_UNUSED_LO = 4'd13;
    localparam logic [KIND_W-1:0] KIND_UNUSED_HI = 4'd15;
    localparam logic [DATA_W-1:0] NEG_ONE        = 32'hFFFF_FFFF;
    localparam logic [DATA_W-1:0] POS_MAX        = 32'h7FFF_FFFF;
    localparam logic [DATA_W-1:0] NEG_MAX        = 32'h8000_0000;

    typedef struct packed {
        logic [DATA_W-1:0] value;
        status_t           status;
        logic [CNT_FW-1:0] count;
    } list_result_t;

    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [RANK_W-1:0]  rank;
        logic [OTHER_W-1:0] other;
        logic [DATA_W-1:0]  value;
        logic               typed;
        list_result_t       want;
    } directed_row_t;

    typedef struct packed {
        logic [CAP_W-1:0] cap;
        logic [6:0]       ins_pct;
        logic [6:0]       del_pct;
        logic [7:0]       items;
    } list_phase_t;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 cfg_wr_en;
    logic [CAP_W-1:0]     cfg_wr_data;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;
    logic [KIND_W-1:0]    s_tuser;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [STAT_W-1:0]    m_tuser;

    // shadow copy of the list
    logic [DATA_W-1:0] shadow_entries [0:ENTRY_DEPTH-1];
    int                shadow_len;
    logic [CAP_W-1:0]  shadow_cap;

    list_result_t  pending_results [$];
    directed_row_t directed_rows [DIRECTED_ROWS];
    list_phase_t   list_phases [PHASES];

    int  err_count;
    int  words_sent;
    int  words_checked;
    int  status_seen [4];
    int  peak_len;
    int  idle_cycles;
    int  burst_left;
    bit  hold_off_req;

    ranked_array_list_core dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Apply one operation to the shadow list and return the result word it gives.
    function automatic list_result_t apply_list_op(input logic [KIND_W-1:0] op,
                                                   input logic [RANK_W-1:0] pos,
                                                   input logic [OTHER_W-1:0] pos_b,
                                                   input logic [DATA_W-1:0] val);
        list_result_t r;
        int           cap;
        int           at;
        logic [DATA_W-1:0] t;
        logic         full;
        logic         empty;

        cap = (shadow_cap == 0) ? 1 :
              ((int'(shadow_cap) > ENTRY_DEPTH) ? ENTRY_DEPTH : int'(shadow_cap));
        full  = shadow_len >= cap;
        empty = shadow_len == 0;
        r.value  = '0;
        r.status = STAT_OK;
        case (op)
            KIND_INS_FRONT, KIND_INS_END, KIND_INS_RANK:
            begin
                if (full)
                    r.status = STAT_FULL;
                else if (op == KIND_INS_RANK && int'(pos) > shadow_len)
                    r.status = STAT_RANGE;
                else
                begin
                    at = (op == KIND_INS_FRONT) ? 0 :
                         ((op == KIND_INS_END) ? shadow_len : int'(pos));
                    for (int i = shadow_len; i > at; i--)
                        shadow_entries[i] = shadow_entries[i-1];
                    shadow_entries[at] = val;
                    shadow_len++;
                end
            end
            KIND_REPLACE, KIND_DEL_RANK, KIND_READ, KIND_DEL_FRONT, KIND_DEL_END:
            begin
                at = (op == KIND_DEL_FRONT) ? 0 :
                     ((op == KIND_DEL_END) ? shadow_len - 1 : int'(pos));
                if (empty)
                    r.status = STAT_EMPTY;
                else if (at >= shadow_len)
                    r.status = STAT_RANGE;
                else if (op == KIND_REPLACE)
                    shadow_entries[at] = val;
                else if (op == KIND_READ)
                    r.value = shadow_entries[at];
                else
                begin
                    r.value = shadow_entries[at];
                    for (int i = at; i + 1 < shadow_len; i++)
                        shadow_entries[i] = shadow_entries[i+1];
                    shadow_len--;
                end
            end
            KIND_SWAP:
            begin
                if (int'(pos) >= shadow_len || int'(pos_b) >= shadow_len)
                    r.status = STAT_RANGE;
                else
                begin
                    t = shadow_entries[pos];
                    shadow_entries[pos] = shadow_entries[pos_b];
                    shadow_entries[pos_b] = t;
                end
            end
            KIND_SUM, KIND_MAX, KIND_MIN, KIND_REVERSE:
            begin
                if (empty)
                    r.status = STAT_EMPTY;
                else if (op == KIND_SUM)
                begin
                    for (int i = 0; i < shadow_len; i++)
                        r.value += shadow_entries[i];
                end
                else if (op == KIND_REVERSE)
                begin
                    for (int i = 0; i < shadow_len / 2; i++)
                    begin
                        t = shadow_entries[i];
                        shadow_entries[i] = shadow_entries[shadow_len-1-i];
                        shadow_entries[shadow_len-1-i] = t;
                    end
                end
                else
                begin
                    r.value = shadow_entries[0];
                    for (int i = 1; i < shadow_len; i++)
                        if ((op == KIND_MAX && $signed(shadow_entries[i]) > $signed(r.value)) ||
                            (op == KIND_MIN && $signed(shadow_entries[i]) < $signed(r.value)))
                            r.value = shadow_entries[i];
                end
            end
            default:
                ;
        endcase
        if (r.status != STAT_OK)
            r.value = NEG_ONE;
        r.count = shadow_len[CNT_FW-1:0];
        if (shadow_len > peak_len)
            peak_len = shadow_len;
        return r;
    endfunction

    // Offer one word; called at a falling edge, returns at a falling edge after accept, at times after a random gap.
    task automatic send_list_op(input logic [KIND_W-1:0] op, input logic [RANK_W-1:0] pos,
                                input logic [OTHER_W-1:0] pos_b, input logic [DATA_W-1:0] val,
                                input logic typed, input list_result_t want);
        list_result_t predicted;

        predicted = apply_list_op(op, pos, pos_b, val);
        pending_results.push_back(typed ? want : predicted);
        s_tdata  = {{PAD_W{1'b0}}, val, pos_b, pos};
        s_tuser  = op;
        s_tvalid = 1'b1;
        do
            @(posedge clk);
        while (!s_tready);
        words_sent++;
        @(negedge clk);
        burst_left--;
        if (burst_left <= 0)
        begin
            s_tvalid = 1'b0;
            if ($urandom_range(0, 9) >= 3)
                repeat ($urandom_range(1, 8)) @(negedge clk);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(1, 12);
        end
    endtask

    // Hold the sender until the list is idle; write_capacity then writes the capacity register.
    task automatic drain_results();
        s_tvalid = 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_capacity(input logic [CAP_W-1:0] cap);
        drain_results();
        cfg_wr_data = cap;
        cfg_wr_en   = 1'b1;
        shadow_cap  = cap;
        @(negedge clk);
        cfg_wr_en   = 1'b0;
    endtask

    // Pick a random operation, mostly well formed for the current list length.
    task automatic pick_list_op(input int ins_pct, input int del_pct,
                                output logic [KIND_W-1:0] op, output logic [RANK_W-1:0] pos,
                                output logic [OTHER_W-1:0] pos_b,
                                output logic [DATA_W-1:0] val);
        int roll;
        int sel;
        int top;

        roll = $urandom_range(0, 99);
        top  = (shadow_len > 0) ? shadow_len - 1 : 0;
        pos   = RANK_W'($urandom_range(0, top));
        pos_b = OTHER_W'($urandom_range(0, (top > 15) ? 15 : top));
        case ($urandom_range(0, 9))
            0: val = POS_MAX;
            1: val = NEG_MAX;
            2: val = NEG_ONE;
            default: val = $urandom;
        endcase
        if (roll < 10)
        begin
            // noise: any field value the word can carry
            op    = KIND_W'($urandom_range(0, 15));
            pos   = RANK_W'($urandom_range(0, 31));
            pos_b = OTHER_W'($urandom_range(0, 15));
            val   = $urandom;
        end
        else if (roll < 10 + ins_pct)
        begin
            sel = $urandom_range(0, 2);
            op  = (sel == 0) ? KIND_INS_FRONT : ((sel == 1) ? KIND_INS_END : KIND_INS_RANK);
            pos = ($urandom_range(0, 9) == 0) ? RANK_W'($urandom_range(0, 31))
                                              : RANK_W'($urandom_range(0, shadow_len));
        end
        else if (roll < 10 + ins_pct + del_pct)
        begin
            sel = $urandom_range(0, 2);
            op  = (sel == 0) ? KIND_DEL_FRONT : ((sel == 1) ? KIND_DEL_END : KIND_DEL_RANK);
        end
        else
        begin
            sel = $urandom_range(0, 19);
            if (sel < 3)       op = KIND_REPLACE;
            else if (sel < 6)  op = KIND_READ;
            else if (sel < 9)  op = KIND_SWAP;
            else if (sel < 11) op = KIND_SUM;
            else if (sel < 13) op = KIND_MAX;
            else if (sel < 15) op = KIND_MIN;
            else if (sel < 18) op = KIND_REVERSE;
            else if (sel < 19) op = KIND_UNUSED_LO;
            else               op = KIND_UNUSED_HI;
            if (op == KIND_SWAP && $urandom_range(0, 4) == 0)
                pos_b = OTHER_W'($urandom_range(0, 15));
        end
    endtask

    // Receiver: rotate through stall patterns, with one long hold-off on request.
    initial
    begin
        int rx_cycle;
        int mode;

        rx_cycle = 0;
        m_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_off_req)
            begin
                m_tready     = 1'b0;
                hold_off_req = 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            rx_cycle++;
            mode = (rx_cycle / 64) % 4;
            case (mode)
                0:       m_tready = 1'b1;
                1:       m_tready = 1'($urandom_range(0, 1));
                2:       m_tready = ($urandom_range(0, 99) < 85);
                default: m_tready = ((rx_cycle % 5) >= 2);
            endcase
        end
    end

    // Result checker: compare each accepted word with the oldest expectation.
    always @(posedge clk)
    begin
        list_result_t want;

        if (rst_n && m_tvalid && m_tready)
        begin
            words_checked++;
            status_seen[m_tuser]++;
            if (pending_results.size() == 0)
            begin
                $error("unexpected result word: result_value %h status %0d entry_count %0d",
                       m_tdata[DATA_W-1:0], m_tuser, m_tdata[DATA_W +: CNT_FW]);
                err_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (m_tdata[DATA_W-1:0] !== want.value)
                begin
                    $error("result_value: expected %h, got %h", want.value,
                           m_tdata[DATA_W-1:0]);
                    err_count++;
                end
                if (m_tuser !== want.status)
                begin
                    $error("status: expected %0d, got %0d", want.status, m_tuser);
                    err_count++;
                end
                if (m_tdata[DATA_W +: CNT_FW] !== want.count)
                begin
                    $error("entry_count: expected %0d, got %0d", want.count,
                           m_tdata[DATA_W +: CNT_FW]);
                    err_count++;
                end
            end
        end
    end

    // Watchdog: end the run if neither side moves a word for too long.
    initial
    begin
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("tb: failure");
        $finish;
    end

    // Stimulus
    initial
    begin
        logic [KIND_W-1:0]  op;
        logic [RANK_W-1:0]  pos;
        logic [OTHER_W-1:0] pos_b;
        logic [DATA_W-1:0]  val;
        list_result_t       unused_want;

        rst_n        = 1'b0;
        cfg_wr_en    = 1'b0;
        cfg_wr_data  = '0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        s_tuser      = '0;
        hold_off_req = 1'b0;
        err_count    = 0;
        words_sent   = 0;
        words_checked = 0;
        status_seen  = '{0, 0, 0, 0};
        peak_len     = 0;
        burst_left   = 8;
        shadow_len   = 0;
        shadow_cap   = CAP_RESET;
        unused_want  = '0;
        for (int i = 0; i < ENTRY_DEPTH; i++)
            shadow_entries[i] = '0;

        // kind, rank, other_rank, value, typed, {result_value, status, entry_count}
        directed_rows = '{
            '{KIND_DEL_FRONT, 5'd0,  4'd0,  32'd0,  1'b1, '{NEG_ONE, STAT_EMPTY, 5'd0}},
            '{KIND_DEL_END,   5'd0,  4'd0,  32'd0,  1'b1, '{NEG_ONE, STAT_EMPTY, 5'd0}},
            '{KIND_DEL_RANK,  5'd0,  4'd0,  32'd0,  1'b1, '{NEG_ONE, STAT_EMPTY, 5'd0}},
            '{KIND_READ,      5'd0,  4'd0,  32'd0,  1'b1, '{NEG_ONE, STAT_EMPTY, 5'd0}},
            '{KIND_REPLACE,   5'd0,  4'd0,  32'd5,  1'b1, '{NEG_ONE, STAT_EMPTY, 5'd0}},
            '{KIND_SUM,       5'd0,  4'd0,  32'd0,  1'b1, '{NEG_ONE, STAT_EMPTY, 5'd0}},
            '{KIND_MAX,       5'd0,  4'd0,  32'd0,  1'b1, '{NEG_ONE, STAT_EMPTY, 5'd0}},
            '{KIND_MIN,       5'd0,  4'd0,  32'd0,  1'b1, '{NEG_ONE, STAT_EMPTY, 5'd0}},
            '{KIND_REVERSE,   5'd0,  4'd0,  32'd0,  1'b1, '{NEG_ONE, STAT_EMPTY, 5'd0}},
            // swap has no empty check, so it reports a range error
            '{KIND_SWAP,      5'd0,  4'd0,  32'd0,  1'b1, '{NEG_ONE, STAT_RANGE, 5'd0}},
            '{KIND_INS_RANK,  5'd1,  4'd0,  32'd9,  1'b1, '{NEG_ONE, STAT_RANGE, 5'd0}},
            '{KIND_UNUSED_HI, 5'd31, 4'd15, NEG_ONE, 1'b1, '{32'd0, STAT_OK, 5'd0}},
            '{KIND_INS_FRONT, 5'd0,  4'd0,  POS_MAX, 1'b1, '{32'd0, STAT_OK, 5'd1}},
            '{KIND_INS_END,   5'd0,  4'd0,  NEG_MAX, 1'b1, '{32'd0, STAT_OK, 5'd2}},
            '{KIND_INS_RANK,  5'd1,  4'd0,  NEG_ONE, 1'b1, '{32'd0, STAT_OK, 5'd3}},
            // insert at rank equal to the count appends
            '{KIND_INS_RANK,  5'd3,  4'd0,  32'd0,  1'b1, '{32'd0, STAT_OK, 5'd4}},
            '{KIND_MAX,       5'd0,  4'd0,  32'd0,  1'b1, '{POS_MAX, STAT_OK, 5'd4}},
            '{KIND_MIN,       5'd0,  4'd0,  32'd0,  1'b1, '{NEG_MAX, STAT_OK, 5'd4}},
            '{KIND_READ,      5'd31, 4'd0,  32'd0,  1'b1, '{NEG_ONE, STAT_RANGE, 5'd4}},
            '{KIND_SWAP,      5'd0,  4'd15, 32'd0,  1'b1, '{NEG_ONE, STAT_RANGE, 5'd4}},
            '{KIND_SUM,       5'd0,  4'd0,  32'd0,  1'b0, '0},
            '{KIND_SWAP,      5'd0,  4'd3,  32'd0,  1'b0, '0},
            '{KIND_REVERSE,   5'd0,  4'd0,  32'd0,  1'b0, '0},
            '{KIND_REPLACE,   5'd2,  4'd0,  32'h1234_5678, 1'b0, '0},
            '{KIND_DEL_RANK,  5'd1,  4'd0,  32'd0,  1'b0, '0}
        };

        // capacity, insert %, delete %, words; the 5 drops below the count left by 16
        list_phases = '{
            '{5'd16, 7'd60, 7'd15, 8'd110},
            '{5'd5,  7'd25, 7'd35, 8'd100},
            '{5'd1,  7'd45, 7'd25, 8'd90},
            '{5'd0,  7'd45, 7'd25, 8'd90},
            '{5'd31, 7'd65, 7'd10, 8'd120},
            '{5'd10, 7'd40, 7'd30, 8'd115}
        };

        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        for (int r = 0; r < DIRECTED_ROWS; r++)
            send_list_op(directed_rows[r].kind, directed_rows[r].rank, directed_rows[r].other,
                         directed_rows[r].value, directed_rows[r].typed, directed_rows[r].want);

        for (int p = 0; p < PHASES; p++)
        begin
            write_capacity(list_phases[p].cap);
            for (int n = 0; n < int'(list_phases[p].items); n++)
            begin
                if (p == 0 && n == 40)
                    hold_off_req = 1'b1;
                if (p == 0 && n == 80)
                    drain_results();
                pick_list_op(int'(list_phases[p].ins_pct), int'(list_phases[p].del_pct),
                             op, pos, pos_b, val);
                send_list_op(op, pos, pos_b, val, 1'b0, unused_want);
            end
        end

        s_tvalid = 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (pending_results.size() != 0)
        begin
            $error("%0d result words never arrived", pending_results.size());
            err_count++;
        end

        $display("tb: %0d words sent, %0d results checked, list length peaked at %0d",
                 words_sent, words_checked, peak_len);
        $display("tb: status ok %0d, full %0d, empty %0d, out of range %0d over 6 capacities",
                 status_seen[STAT_OK], status_seen[STAT_FULL], status_seen[STAT_EMPTY],
                 status_seen[STAT_RANGE]);
        if (err_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

>>> files.f
sv/ral_pkg.sv
sv/ral_cell.sv
sv/ranked_array_list_core.sv
bench/ranked_array_list_core_tb.sv
